// ===== hdl/cate_pkg.sv =====
// shared types and constants of the crank angle event table
// used by cate_alu and crank_angle_event_table; depends on nothing
`default_nettype none

package cate_pkg;

   localparam int VAL_W       = 18;
   localparam int CYCLE_UNITS = 46080;
   localparam int MAX_RESULTS = 32;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   localparam logic CSR_TRIGGER_OFFSET = 1'b0;
   localparam logic CSR_TOOTH_COUNT    = 1'b1;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_LOAD  = 2'd1,
      ACT_REG   = 2'd2,
      ACT_FIND  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      STS_DONE  = 3'd0,
      STS_REG   = 3'd1,
      STS_FULL  = 3'd2,
      STS_FOUND = 3'd3,
      STS_NONE  = 3'd4
   } status_type;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      alu_op_type              op;
      logic signed [VAL_W-1:0] a;
      logic signed [VAL_W-1:0] b;
   } alu_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_WRAP,
      ST_TREAD,
      ST_TCMP,
      ST_REM,
      ST_FREAD,
      ST_FCMP,
      ST_FEND,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

// ===== hdl/cate_alu.sv =====
// shared add/subtract unit of the crank angle event table sequencer
// depends on cate_pkg
`default_nettype none

module cate_alu
   import cate_pkg::*;
(
   input  alu_req_type             alu_req,
   output logic signed [VAL_W-1:0] alu_res
);

   always_comb begin
      case (alu_req.op)
         ALU_ADD: alu_res = alu_req.a + alu_req.b;
         ALU_SUB: alu_res = alu_req.a - alu_req.b;
         default: alu_res = alu_req.a;
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/crank_angle_event_table.sv =====
// crank angle event table: tooth angle memory, event memory and sequencer
// depends on cate_pkg and cate_alu
//
// requests come in on req_*, results leave on rsp_* (tlast on the final one
// of a request). tuser carries the action on the request side and the status
// on the result side. the csr port writes trigger_offset (index 0) and
// tooth_count (index 1) in the cycle csr_we is high.
// one request is worked on at a time; req_tready is high only between them.
// clear and load go straight to the result. register sums the angle and the
// offset, wraps it into the crank cycle and scans at most MAX_TEETH teeth: each tooth
// is one read of the tooth memory and one pass through the shared subtractor.
// find reads the stored events in order and sends one result per match (at
// most 32) or a single no-match result.
// reset (synchronous) empties the event list and sets trigger_offset to 0
// and tooth_count to 1; tooth angles keep whatever was last loaded.
// a result waits in the output register while rsp_tready is low; the next
// request is still taken then, and the sequencer only pauses when it has a
// further result to send.
`default_nettype none

module crank_angle_event_table
   import cate_pkg::*;
#(
   parameter int MAX_EVENTS = 32,
   parameter int MAX_TEETH  = 64
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tooth_index, tooth_angle, actuator_id, requested_angle
   input  logic [47:0] req_tdata,
   // action
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // event_tooth, event_actuator, event_offset
   output logic [31:0] rsp_tdata,
   // status
   output logic [2:0]  rsp_tuser,
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [16:0] csr_wdata
);

   localparam int TW   = (MAX_TEETH > 1) ? $clog2(MAX_TEETH) : 1;
   localparam int NW   = TW + 1;
   localparam int EW   = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
   localparam int CW   = $clog2(MAX_EVENTS + 1);
   localparam int QW   = (TW > 6) ? TW : 6;
   localparam int EV_W = TW + 24;

   state_type state_ff, state_in;

   logic signed [16:0] offset_ff, offset_in;
   logic [6:0]         tcount_ff, tcount_in;
   logic [CW-1:0]      count_ff, count_in;

   logic [1:0]  action_ff, action_in;
   logic [5:0]  tidx_ff, tidx_in;
   logic [7:0]  actuator_ff, actuator_in;
   logic signed [16:0] req_ang_ff, req_ang_in;

   logic signed [VAL_W-1:0] ang_ff, ang_in;
   logic signed [VAL_W-1:0] prev_rel_ff, prev_rel_in;
   logic [15:0]   first_ff, first_in;
   logic [TW-1:0] i_ff, i_in;
   logic [NW-1:0] n_ff, n_in;
   logic [CW-1:0] j_ff, j_in;
   logic [RES_W-1:0] k_ff, k_in;

   status_type  pend_status_ff, pend_status_in;
   logic [5:0]  pend_tooth_ff, pend_tooth_in;
   logic [7:0]  pend_act_ff, pend_act_in;
   logic [15:0] pend_off_ff, pend_off_in;
   logic        pend_last_ff, pend_last_in;
   logic        pend_valid_ff, pend_valid_in;

   logic        rsp_valid_ff, rsp_valid_in;
   status_type  rsp_status_ff, rsp_status_in;
   logic [5:0]  rsp_tooth_ff, rsp_tooth_in;
   logic [7:0]  rsp_act_ff, rsp_act_in;
   logic [15:0] rsp_off_ff, rsp_off_in;
   logic        rsp_last_ff, rsp_last_in;

   logic [15:0]   tooth_mem [MAX_TEETH];
   logic [15:0]   tooth_rd_ff;
   logic          tooth_we;
   logic [TW-1:0] tooth_waddr;
   logic          tooth_re;
   logic [TW-1:0] tooth_raddr;

   logic [EV_W-1:0] event_mem [MAX_EVENTS];
   logic [EV_W-1:0] ev_rd_ff;
   logic            ev_we;
   logic [EV_W-1:0] ev_wdata;
   logic            ev_re;

   alu_req_type             alu_req;
   logic signed [VAL_W-1:0] alu_res;

   logic          req_fire;
   logic          out_free;
   logic          push;
   logic [NW-1:0] nxt;
   logic [NW-1:0] n_clamp;
   logic [15:0]   rem_clamp;
   logic          ev_match;
   logic [RES_W-1:0] k_nxt;

   cate_alu u_alu (
      .alu_req (alu_req),
      .alu_res (alu_res)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign nxt        = {1'b0, i_ff} + NW'(1);
   assign k_nxt      = k_ff + RES_W'(1);
   assign ev_match   = (QW'(ev_rd_ff[EV_W-1:24]) == QW'(tidx_ff));

   always_comb begin
      if (tcount_ff == 7'd0) begin
         n_clamp = NW'(1);
      end else if (32'(tcount_ff) > MAX_TEETH) begin
         n_clamp = NW'(MAX_TEETH);
      end else begin
         n_clamp = NW'(tcount_ff);
      end
   end

   always_comb begin
      if (alu_res < 0) begin
         rem_clamp = 16'd0;
      end else if (alu_res > VAL_W'(CYCLE_UNITS - 1)) begin
         rem_clamp = 16'(CYCLE_UNITS - 1);
      end else begin
         rem_clamp = alu_res[15:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      offset_in      = offset_ff;
      tcount_in      = tcount_ff;
      count_in       = count_ff;
      action_in      = action_ff;
      tidx_in        = tidx_ff;
      actuator_in    = actuator_ff;
      req_ang_in     = req_ang_ff;
      ang_in         = ang_ff;
      prev_rel_in    = prev_rel_ff;
      first_in       = first_ff;
      i_in           = i_ff;
      n_in           = n_ff;
      j_in           = j_ff;
      k_in           = k_ff;
      pend_status_in = pend_status_ff;
      pend_tooth_in  = pend_tooth_ff;
      pend_act_in    = pend_act_ff;
      pend_off_in    = pend_off_ff;
      pend_last_in   = pend_last_ff;
      pend_valid_in  = pend_valid_ff;
      push           = 1'b0;
      tooth_we       = 1'b0;
      tooth_waddr    = TW'(req_tdata[5:0]);
      tooth_re       = 1'b0;
      tooth_raddr    = '0;
      ev_we          = 1'b0;
      ev_wdata       = {i_ff, actuator_ff, rem_clamp};
      ev_re          = 1'b0;
      alu_req.op     = ALU_ADD;
      alu_req.a      = '0;
      alu_req.b      = '0;

      if (csr_we) begin
         if (csr_index == CSR_TRIGGER_OFFSET) begin
            offset_in = csr_wdata;
         end else begin
            tcount_in = csr_wdata[6:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               action_in      = req_tuser;
               tidx_in        = req_tdata[5:0];
               actuator_in    = req_tdata[29:22];
               req_ang_in     = req_tdata[46:30];
               pend_status_in = STS_DONE;
               pend_tooth_in  = '0;
               pend_act_in    = '0;
               pend_off_in    = '0;
               pend_last_in   = 1'b1;
               pend_valid_in  = 1'b0;
               case (action_type'(req_tuser))
                  ACT_CLEAR: begin
                     count_in = '0;
                     state_in = ST_EMIT;
                  end
                  ACT_LOAD: begin
                     tooth_we = (32'(req_tdata[5:0]) < MAX_TEETH);
                     state_in = ST_EMIT;
                  end
                  ACT_REG: begin
                     if (count_ff == CW'(MAX_EVENTS)) begin
                        pend_status_in = STS_FULL;
                        state_in       = ST_EMIT;
                     end else begin
                        state_in = ST_SUM;
                     end
                  end
                  default: begin
                     j_in     = '0;
                     k_in     = '0;
                     state_in = ST_FREAD;
                  end
               endcase
            end
         end
         ST_SUM: begin
            alu_req.op  = ALU_ADD;
            alu_req.a   = VAL_W'(req_ang_ff);
            alu_req.b   = VAL_W'(offset_ff);
            ang_in      = alu_res;
            n_in        = n_clamp;
            tooth_re    = 1'b1;
            tooth_raddr = '0;
            state_in    = ST_WRAP;
         end
         ST_WRAP: begin
            first_in = tooth_rd_ff;
            if (ang_ff >= VAL_W'(CYCLE_UNITS)) begin
               alu_req.op = ALU_SUB;
               alu_req.a  = ang_ff;
               alu_req.b  = VAL_W'(CYCLE_UNITS);
               ang_in     = alu_res;
            end else if (ang_ff < 0) begin
               alu_req.op = ALU_ADD;
               alu_req.a  = ang_ff;
               alu_req.b  = VAL_W'(CYCLE_UNITS);
               ang_in     = alu_res;
            end else begin
               i_in        = '0;
               prev_rel_in = '0;
               state_in    = ST_TREAD;
            end
         end
         ST_TREAD: begin
            if (nxt < n_ff) begin
               tooth_re    = 1'b1;
               tooth_raddr = nxt[TW-1:0];
               state_in    = ST_TCMP;
            end else begin
               state_in = ST_REM;
            end
         end
         ST_TCMP: begin
            alu_req.op = ALU_SUB;
            alu_req.a  = {2'b00, tooth_rd_ff};
            alu_req.b  = {2'b00, first_ff};
            if (alu_res > ang_ff) begin
               state_in = ST_REM;
            end else begin
               prev_rel_in = alu_res;
               i_in        = nxt[TW-1:0];
               state_in    = ST_TREAD;
            end
         end
         ST_REM: begin
            alu_req.op     = ALU_SUB;
            alu_req.a      = ang_ff;
            alu_req.b      = prev_rel_ff;
            ev_we          = 1'b1;
            count_in       = count_ff + CW'(1);
            pend_status_in = STS_REG;
            pend_tooth_in  = 6'(i_ff);
            pend_act_in    = actuator_ff;
            pend_off_in    = rem_clamp;
            pend_last_in   = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_FREAD: begin
            if (j_ff < count_ff) begin
               ev_re    = 1'b1;
               state_in = ST_FCMP;
            end else begin
               state_in = ST_FEND;
            end
         end
         ST_FCMP: begin
            if (!ev_match) begin
               j_in     = j_ff + CW'(1);
               state_in = ST_FREAD;
            end else if (!pend_valid_ff || out_free) begin
               push           = pend_valid_ff;
               pend_valid_in  = 1'b1;
               pend_status_in = STS_FOUND;
               pend_tooth_in  = 6'(ev_rd_ff[EV_W-1:24]);
               pend_act_in    = ev_rd_ff[23:16];
               pend_off_in    = ev_rd_ff[15:0];
               k_in           = k_nxt;
               j_in           = j_ff + CW'(1);
               if (k_nxt == RES_W'(MAX_RESULTS)) begin
                  pend_last_in = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  pend_last_in = 1'b0;
                  state_in     = ST_FREAD;
               end
            end
         end
         ST_FEND: begin
            pend_last_in = 1'b1;
            if (!pend_valid_ff) begin
               pend_status_in = STS_NONE;
               pend_tooth_in  = '0;
               pend_act_in    = '0;
               pend_off_in    = '0;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               push          = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_tooth_in  = rsp_tooth_ff;
      rsp_act_in    = rsp_act_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_last_in   = rsp_last_ff;
      if (push) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = pend_status_ff;
         rsp_tooth_in  = pend_tooth_ff;
         rsp_act_in    = pend_act_ff;
         rsp_off_in    = pend_off_ff;
         rsp_last_in   = pend_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         offset_ff     <= '0;
         tcount_ff     <= 7'd1;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         offset_ff     <= offset_in;
         tcount_ff     <= tcount_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      tidx_ff        <= tidx_in;
      actuator_ff    <= actuator_in;
      req_ang_ff     <= req_ang_in;
      ang_ff         <= ang_in;
      prev_rel_ff    <= prev_rel_in;
      first_ff       <= first_in;
      i_ff           <= i_in;
      n_ff           <= n_in;
      j_ff           <= j_in;
      k_ff           <= k_in;
      pend_status_ff <= pend_status_in;
      pend_tooth_ff  <= pend_tooth_in;
      pend_act_ff    <= pend_act_in;
      pend_off_ff    <= pend_off_in;
      pend_last_ff   <= pend_last_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tooth_ff   <= rsp_tooth_in;
      rsp_act_ff     <= rsp_act_in;
      rsp_off_ff     <= rsp_off_in;
      rsp_last_ff    <= rsp_last_in;
   end

   // tooth angle memory
   always_ff @(posedge clock) begin
      if (tooth_we) begin
         tooth_mem[tooth_waddr] <= req_tdata[21:6];
      end
      if (tooth_re) begin
         tooth_rd_ff <= tooth_mem[tooth_raddr];
      end
   end

   // event memory
   always_ff @(posedge clock) begin
      if (ev_we) begin
         event_mem[count_ff[EW-1:0]] <= ev_wdata;
      end
      if (ev_re) begin
         ev_rd_ff <= event_mem[j_ff[EW-1:0]];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {2'b00, rsp_off_ff, rsp_act_ff, rsp_tooth_ff};

   // request in progress is a find
   logic action_is_find;
   assign action_is_find = (action_type'(action_ff) == ACT_FIND);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_EVENTS)
      else $error("event count above table size");

   a_not_last_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == STS_FOUND)
      else $error("non-final result without found status");

   a_reg_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REM |=> count_ff == $past(count_ff) + CW'(1))
      else $error("register did not add one event");

   a_find_state: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FCMP |-> action_is_find)
      else $error("event scan outside a find request");

endmodule

`default_nettype wire

// ===== tb/sv/crank_angle_event_table_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench of crank_angle_event_table: directed and random requests,
// a predictor of the tooth and event tables, and a result checker with random stalls
// depends on cate_pkg and the crank_angle_event_table rtl

module crank_angle_event_table_tb;
   import cate_pkg::*;

   localparam int EVENT_SLOTS    = 32;
   localparam int TOOTH_SLOTS    = 64;
   localparam int TOOTH_PITCH    = CYCLE_UNITS / TOOTH_SLOTS;
   localparam int IDLE_SETTLE    = 2 * TOOTH_SLOTS + 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int REPORT_LIMIT   = 10;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_REQUESTS = 32;

   typedef struct {
      action_type         action;
      logic [5:0]         tooth_index;
      logic [15:0]        tooth_angle;
      logic [7:0]         actuator_id;
      logic signed [16:0] requested_angle;
   } table_request_type;

   typedef struct {
      status_type  status;
      logic [5:0]  tooth;
      logic [7:0]  actuator;
      logic [15:0] offset;
      logic        last;
   } table_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [16:0] csr_wdata = '0;

   crank_angle_event_table #(
      .MAX_EVENTS(EVENT_SLOTS),
      .MAX_TEETH (TOOTH_SLOTS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      // tooth_index, tooth_angle, actuator_id, requested_angle
      .req_tdata (req_tdata),
      // action
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      // event_tooth, event_actuator, event_offset
      .rsp_tdata (rsp_tdata),
      // status
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted state of the block
   logic [15:0]        tooth_tab [TOOTH_SLOTS];
   logic [5:0]         ev_tooth [EVENT_SLOTS];
   logic [7:0]         ev_actuator [EVENT_SLOTS];
   logic [15:0]        ev_offset [EVENT_SLOTS];
   int                 ev_count = 0;
   logic signed [16:0] trig_offset = '0;
   logic [6:0]         teeth_cfg = 7'd1;

   table_result_type awaited_results[$];

   int burst_left = 0;
   int n_requests = 0;
   int n_results = 0;
   int n_stored = 0;
   int n_full = 0;
   int n_hits = 0;
   int n_csr_writes = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   int cycle_count = 0;
   int stall_mode = 0;

   function automatic void compute_table_results(input table_request_type r);
      table_result_type res;
      int angle_sum, ang, first, rem, n, i, hits, k;
      res.status   = STS_DONE;
      res.tooth    = '0;
      res.actuator = '0;
      res.offset   = '0;
      res.last     = 1'b1;
      case (r.action)
         ACT_CLEAR: begin
            ev_count = 0;
            awaited_results.push_back(res);
         end
         ACT_LOAD: begin
            tooth_tab[r.tooth_index] = r.tooth_angle;
            awaited_results.push_back(res);
         end
         ACT_REG: begin
            if (ev_count >= EVENT_SLOTS) begin
               res.status = STS_FULL;
               n_full++;
            end else begin
               angle_sum = int'(r.requested_angle) + int'(trig_offset);
               ang = angle_sum % CYCLE_UNITS;
               if (ang < 0) ang += CYCLE_UNITS;
               n = int'(teeth_cfg);
               if (n == 0) n = 1;
               if (n > TOOTH_SLOTS) n = TOOTH_SLOTS;
               // last tooth at or below the angle, relative to tooth 0
               first = int'(tooth_tab[0]);
               for (i = 0; i + 1 < n; i++) begin
                  if (int'(tooth_tab[i+1]) - first > ang) break;
               end
               rem = ang - (int'(tooth_tab[i]) - first);
               if (rem < 0) rem = 0;
               if (rem > CYCLE_UNITS - 1) rem = CYCLE_UNITS - 1;
               ev_tooth[ev_count]    = 6'(i);
               ev_actuator[ev_count] = r.actuator_id;
               ev_offset[ev_count]   = 16'(rem);
               res.status   = STS_REG;
               res.tooth    = ev_tooth[ev_count];
               res.actuator = r.actuator_id;
               res.offset   = 16'(rem);
               ev_count++;
               n_stored++;
            end
            awaited_results.push_back(res);
         end
         default: begin
            hits = 0;
            for (i = 0; i < ev_count; i++) begin
               if (ev_tooth[i] == r.tooth_index) hits++;
            end
            if (hits > MAX_RESULTS) hits = MAX_RESULTS;
            if (hits == 0) begin
               res.status = STS_NONE;
               awaited_results.push_back(res);
            end else begin
               k = 0;
               for (i = 0; i < ev_count && k < hits; i++) begin
                  if (ev_tooth[i] == r.tooth_index) begin
                     res.status   = STS_FOUND;
                     res.tooth    = ev_tooth[i];
                     res.actuator = ev_actuator[i];
                     res.offset   = ev_offset[i];
                     res.last     = (k == hits - 1);
                     awaited_results.push_back(res);
                     k++;
                  end
               end
            end
            n_hits += hits;
         end
      endcase
   endfunction

   function automatic table_request_type make_request(input action_type act, input int tooth,
                                                      input int angle, input int actuator,
                                                      input int req_angle);
      table_request_type r;
      r.action          = act;
      r.tooth_index     = 6'(tooth);
      r.tooth_angle     = 16'(angle);
      r.actuator_id     = 8'(actuator);
      r.requested_angle = 17'(req_angle);
      return r;
   endfunction

   function automatic int random_angle();
      return int'($urandom_range(0, 2 * CYCLE_UNITS - 1)) - CYCLE_UNITS;
   endfunction

   function automatic table_request_type random_request();
      return make_request(action_type'($urandom_range(0, 3)), $urandom_range(0, 63),
                          $urandom_range(0, CYCLE_UNITS - 1), $urandom_range(0, 255),
                          random_angle());
   endfunction

   function automatic table_request_type find_request();
      table_request_type r;
      r = random_request();
      r.action = ACT_FIND;
      if (ev_count > 0 && $urandom_range(0, 3) != 0)
         r.tooth_index = ev_tooth[$urandom_range(0, ev_count - 1)];
      return r;
   endfunction

   task automatic note_failure(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%s", msg);
   endtask

   task automatic send_request(input table_request_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, r.requested_angle, r.actuator_id, r.tooth_angle, r.tooth_index};
      req_tuser  <= r.action;
      do @(posedge clock); while (req_tready !== 1'b1);
      compute_table_results(r);
      n_requests++;
   endtask

   // pause the request side until every result is back and the sequencer is quiet
   task automatic drain_results();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 17'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_TRIGGER_OFFSET) trig_offset = 17'(value);
      else teeth_cfg = 7'(value);
      n_csr_writes++;
      @(posedge clock);
   endtask

   task automatic check_table_result();
      table_result_type got, want;
      got.status   = status_type'(rsp_tuser);
      got.tooth    = rsp_tdata[5:0];
      got.actuator = rsp_tdata[13:6];
      got.offset   = rsp_tdata[29:14];
      got.last     = rsp_tlast;
      n_results++;
      if (awaited_results.size() == 0) begin
         note_failure($sformatf("unexpected result: status %0d tooth %0d act %0d off %0d last %0b",
                                got.status, got.tooth, got.actuator, got.offset, got.last));
         return;
      end
      want = awaited_results.pop_front();
      if (got.status !== want.status || got.tooth !== want.tooth ||
          got.actuator !== want.actuator || got.offset !== want.offset ||
          got.last !== want.last)
         note_failure($sformatf({"result %0d mismatch: status %0d/%0d tooth %0d/%0d ",
                                 "act %0d/%0d off %0d/%0d last %0b/%0b (expected/actual)"},
                                n_results, want.status, got.status, want.tooth, got.tooth,
                                want.actuator, got.actuator, want.offset, got.offset,
                                want.last, got.last));
   endtask

   // receiver with its own stall pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 97 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= (cycle_count % 4 != 0);
         2: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= (cycle_count % 16 < 3);
      endcase
      if (rsp_tvalid === 1'b1 && rsp_tready) check_table_result();
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles without a handshake", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic test_directed_basics();
      write_csr(CSR_TOOTH_COUNT, 4);
      write_csr(CSR_TRIGGER_OFFSET, 0);
      send_request(make_request(ACT_CLEAR, 0, 0, 0, 0));
      send_request(make_request(ACT_LOAD, 0, 0, 0, 0));
      send_request(make_request(ACT_LOAD, 1, 11520, 0, 0));
      send_request(make_request(ACT_LOAD, 2, 23040, 0, 0));
      send_request(make_request(ACT_LOAD, 3, 34560, 0, 0));
      send_request(make_request(ACT_LOAD, 63, CYCLE_UNITS - 1, 0, 0));
      send_request(make_request(ACT_REG, 0, 0, 0, 0));
      send_request(make_request(ACT_REG, 0, 0, 255, CYCLE_UNITS - 1));
      send_request(make_request(ACT_REG, 0, 0, 17, -CYCLE_UNITS));
      send_request(make_request(ACT_REG, 0, 0, 128, -1));
      send_request(make_request(ACT_FIND, 3, 0, 0, 0));
      send_request(make_request(ACT_FIND, 0, 0, 0, 0));
      send_request(make_request(ACT_FIND, 5, 0, 0, 0));
      // offset extremes, sum wraps both ways
      drain_results();
      write_csr(CSR_TRIGGER_OFFSET, CYCLE_UNITS - 1);
      send_request(make_request(ACT_REG, 0, 0, 1, CYCLE_UNITS - 1));
      send_request(make_request(ACT_REG, 0, 0, 2, 1));
      drain_results();
      write_csr(CSR_TRIGGER_OFFSET, -CYCLE_UNITS);
      send_request(make_request(ACT_REG, 0, 0, 3, -CYCLE_UNITS));
      // tooth count zero behaves as one tooth
      drain_results();
      write_csr(CSR_TRIGGER_OFFSET, 0);
      write_csr(CSR_TOOTH_COUNT, 0);
      send_request(make_request(ACT_REG, 0, 0, 4, 30000));
   endtask

   // tooth 0 above tooth 1: relative angle goes negative, offset saturates
   task automatic test_unordered_teeth();
      drain_results();
      write_csr(CSR_TOOTH_COUNT, 2);
      send_request(make_request(ACT_LOAD, 0, 30000, 0, 0));
      send_request(make_request(ACT_REG, 0, 0, 90, 40000));
      send_request(make_request(ACT_REG, 0, 0, 91, 1000));
      send_request(make_request(ACT_LOAD, 0, 0, 0, 0));
   endtask

   // fill every slot on one tooth, overflow it, then read all back in one find
   task automatic test_table_capacity();
      table_request_type r;
      int j;
      drain_results();
      write_csr(CSR_TOOTH_COUNT, 1);
      send_request(make_request(ACT_CLEAR, 0, 0, 0, 0));
      for (j = 0; j < EVENT_SLOTS + 1; j++) begin
         r = random_request();
         r.action = ACT_REG;
         send_request(r);
      end
      send_request(make_request(ACT_FIND, 0, 0, 0, 0));
      send_request(make_request(ACT_FIND, 63, 0, 0, 0));
      drain_results();
   endtask

   task automatic test_tooth_table_load();
      int j;
      for (j = 0; j < TOOTH_SLOTS; j++)
         send_request(make_request(ACT_LOAD, j, j * TOOTH_PITCH + $urandom_range(0, TOOTH_PITCH - 1),
                                   $urandom_range(0, 255), random_angle()));
   endtask

   task automatic run_event_sequence();
      table_request_type r;
      int kind, j, nreg, nfind;
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
         if ($urandom_range(0, 2) == 0) begin
            r = random_request();
            r.action = ACT_CLEAR;
            send_request(r);
         end
         nreg = $urandom_range(1, 6);
         for (j = 0; j < nreg; j++) begin
            r = random_request();
            r.action = ACT_REG;
            send_request(r);
         end
         nfind = $urandom_range(1, 3);
         for (j = 0; j < nfind; j++) send_request(find_request());
      end else if (kind == 7) begin
         r = random_request();
         r.action = ACT_LOAD;
         if ($urandom_range(0, 3) != 0)
            r.tooth_angle = 16'(int'(r.tooth_index) * TOOTH_PITCH +
                                $urandom_range(0, TOOTH_PITCH - 1));
         send_request(r);
      end else if (kind == 8) begin
         send_request(random_request());
      end else begin
         r = random_request();
         r.action = ACT_FIND;
         send_request(r);
      end
   endtask

   task automatic test_random_traffic();
      int offset_set[RANDOM_PHASES];
      int count_set[RANDOM_PHASES];
      int p, stop_at;
      offset_set = '{0, CYCLE_UNITS - 1, -CYCLE_UNITS, -1, 23040, 0, 0, 0};
      count_set  = '{TOOTH_SLOTS, 1, 127, 2, TOOTH_SLOTS, 0, 0, 0};
      for (p = 0; p < RANDOM_PHASES; p++) begin
         if (p >= 5) begin
            offset_set[p] = random_angle();
            count_set[p]  = $urandom_range(1, TOOTH_SLOTS);
         end
         drain_results();
         write_csr(CSR_TRIGGER_OFFSET, offset_set[p]);
         write_csr(CSR_TOOTH_COUNT, count_set[p]);
         stop_at = n_requests + PHASE_REQUESTS;
         while (n_requests < stop_at) run_event_sequence();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_directed_basics();
      test_unordered_teeth();
      test_table_capacity();
      test_tooth_table_load();
      test_random_traffic();
      drain_results();
      $display("ran %0d requests and checked %0d results over %0d register writes",
               n_requests, n_results, n_csr_writes);
      $display("events stored %0d, refused as full %0d, returned by finds %0d",
               n_stored, n_full, n_hits);
      if (mismatches == 0 && awaited_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures, %0d results never arrived", mismatches,
                  awaited_results.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
